>>> rtl/lcag_pkg.sv
// Package for the life cellular automaton grid unit.
// Holds the item structs, operation codes, state encoding and preset pattern table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcag_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned COORD_W    = 4;
  localparam int unsigned ROW_BITS_W = 16;

  // Preset patterns occupy the first few rows and columns of the grid.
  localparam int unsigned PRESET_W    = 6;
  localparam int unsigned PRESET_ROWS = 6;
  localparam int unsigned LD_CNT_W    = 3;

  // Operation codes carried by an input item.
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd3;

  // Preset selection held in the configuration register.
  localparam logic PATTERN_GLIDER = 1'b0;
  localparam logic PATTERN_TETRIS = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               cell_value;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]    row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WR_WB,
    ST_ADV_FILL,
    ST_ADV_RUN,
    ST_RD_RUN
  } state_t;

  // Row contents of the preset patterns, bit j being column j.
  function automatic logic [PRESET_W-1:0] preset_row(input logic pattern,
                                                     input logic [LD_CNT_W-1:0] r);
    logic [PRESET_W-1:0] bits;
    bits = '0;
    if (pattern == PATTERN_TETRIS) begin
      case (r)
        3'd4:    bits = 6'b010000;
        3'd5:    bits = 6'b111000;
        default: bits = '0;
      endcase
    end else begin
      case (r)
        3'd0:    bits = 6'b000001;
        3'd1:    bits = 6'b000110;
        3'd2:    bits = 6'b000011;
        default: bits = '0;
      endcase
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lcag_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lcag_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and a read whose data holds until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lcag_rule.sv
// Next-generation rule (born on three, survives on two or three) for one grid row.
// Takes the rows above, at and below; cells beyond the edge count as dead.
`timescale 1ns / 1ps
`default_nettype none

module lcag_rule #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  wire logic [GRID_SIZE-1:0] above_row,
  input  wire logic [GRID_SIZE-1:0] centre_row,
  input  wire logic [GRID_SIZE-1:0] below_row,
  output logic      [GRID_SIZE-1:0] next_row
);

  // Rows padded with a dead cell at each end.
  logic [GRID_SIZE+1:0] above_ext;
  logic [GRID_SIZE+1:0] centre_ext;
  logic [GRID_SIZE+1:0] below_ext;

  assign above_ext  = {1'b0, above_row, 1'b0};
  assign centre_ext = {1'b0, centre_row, 1'b0};
  assign below_ext  = {1'b0, below_row, 1'b0};

  // Each column counts its eight neighbours independently.
  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
    logic [3:0] count;
    assign count = 4'(above_ext[c]) + 4'(above_ext[c+1]) + 4'(above_ext[c+2])
                 + 4'(centre_ext[c]) + 4'(centre_ext[c+2])
                 + 4'(below_ext[c]) + 4'(below_ext[c+1]) + 4'(below_ext[c+2]);
    assign next_row[c] = (count == 4'd3) || (centre_row[c] && (count == 4'd2));
  end

endmodule

`default_nettype wire

>>> rtl/life_cellular_automaton_grid_unit.sv
// Top level of the life cellular automaton grid unit: grid memory, sequencer and output register.
// Depends on lcag_pkg, lcag_ram and lcag_rule.
`timescale 1ns / 1ps
`default_nettype none

// The grid lives in one RAM of GRID_SIZE rows, one row per word, with a valid flag per
// row so that reset and the load operation clear the whole grid at once. A load writes
// the preset rows in turn once accepted, and a cell write fetches the row at
// acceptance, then modifies it and writes it back. An advance or read streams the
// grid through the RAM's single read port one row a cycle while the output is not
// stalled, an advance first filling the three-row window. An advance computes each
// new row from the window and writes it back as it is emitted. A new item is taken as
// soon as the last row sits in the output register. Writes outside the grid are
// dropped in their acceptance cycle, and rows wider than 16 cells are emitted as their
// low 16 columns.
module life_cellular_automaton_grid_unit #(
  parameter int unsigned GRID_SIZE = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lcag_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lcag_pkg::out_item_t     out_data,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data
);

  localparam int unsigned IDX_W = $clog2(GRID_SIZE);
  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(GRID_SIZE - 1);
  localparam logic [IDX_W-1:0] PENULT_ROW = IDX_W'(GRID_SIZE - 2);

  // Control registers.
  lcag_pkg::state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]                  idx_r, idx_nxt;
  logic [lcag_pkg::LD_CNT_W-1:0]     ld_cnt_r, ld_cnt_nxt;
  logic [GRID_SIZE-1:0]              row_valid_r, row_valid_nxt;
  logic                              rd_valid_r, rd_valid_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              pattern_r;

  // Payload registers.
  logic [IDX_W-1:0]                  wr_row_r, wr_row_nxt;
  logic [lcag_pkg::COORD_W-1:0]      wr_col_r, wr_col_nxt;
  logic                              wr_val_r, wr_val_nxt;
  logic [GRID_SIZE-1:0]              prev_r, prev_nxt;
  logic [GRID_SIZE-1:0]              cur_r, cur_nxt;
  lcag_pkg::out_item_t               out_data_r, out_data_nxt;

  // RAM port signals.
  logic                              ram_wr_en;
  logic [IDX_W-1:0]                  ram_wr_addr;
  logic [GRID_SIZE-1:0]              ram_wr_data;
  logic                              ram_rd_en;
  logic [IDX_W-1:0]                  ram_rd_addr;
  logic [GRID_SIZE-1:0]              ram_rd_data;

  // Datapath signals.
  logic                              step;
  logic                              wr_in_range;
  logic [GRID_SIZE-1:0]              rd_row;
  logic [GRID_SIZE-1:0]              below_row;
  logic [GRID_SIZE-1:0]              new_row;
  logic [GRID_SIZE-1:0]              col_mask;
  logic [GRID_SIZE-1:0]              modified_row;

  lcag_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_grid_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  lcag_rule #(
    .GRID_SIZE (GRID_SIZE)
  ) u_rule (
    .above_row  (prev_r),
    .centre_row (cur_r),
    .below_row  (below_row),
    .next_row   (new_row)
  );

  // The output register can take a row when it is empty or being emptied.
  assign step = !out_valid_r || out_ready;

  // A row whose valid flag was clear at read time reads as all dead.
  assign rd_row    = ram_rd_data & {GRID_SIZE{rd_valid_r}};
  assign below_row = (idx_r == LAST_ROW) ? '0 : rd_row;

  assign wr_in_range = (32'(in_data.row) < 32'(GRID_SIZE))
                    && (32'(in_data.col) < 32'(GRID_SIZE));

  // Single-cell update of the row fetched for a write item.
  assign col_mask     = {{(GRID_SIZE-1){1'b0}}, 1'b1} << wr_col_r;
  assign modified_row = (rd_row & ~col_mask) | (wr_val_r ? col_mask : '0);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lcag_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.func)
            lcag_pkg::FUNC_LOAD:    state_nxt = lcag_pkg::ST_LOAD;
            lcag_pkg::FUNC_WRITE: begin
              state_nxt = wr_in_range ? lcag_pkg::ST_WR_WB : lcag_pkg::ST_IDLE;
            end
            lcag_pkg::FUNC_ADVANCE: state_nxt = lcag_pkg::ST_ADV_FILL;
            lcag_pkg::FUNC_READ:    state_nxt = lcag_pkg::ST_RD_RUN;
            default:                state_nxt = lcag_pkg::ST_IDLE;
          endcase
        end
      end
      lcag_pkg::ST_LOAD: begin
        if (ld_cnt_r == lcag_pkg::LD_CNT_W'(lcag_pkg::PRESET_ROWS - 1)) begin
          state_nxt = lcag_pkg::ST_IDLE;
        end
      end
      lcag_pkg::ST_WR_WB:    state_nxt = lcag_pkg::ST_IDLE;
      lcag_pkg::ST_ADV_FILL: state_nxt = lcag_pkg::ST_ADV_RUN;
      lcag_pkg::ST_ADV_RUN, lcag_pkg::ST_RD_RUN: begin
        if (step && (idx_r == LAST_ROW)) begin
          state_nxt = lcag_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lcag_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM accesses and next values of the datapath.
  always_comb begin
    in_ready      = 1'b0;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = idx_r;
    ram_wr_data   = new_row;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = idx_r;
    idx_nxt       = idx_r;
    ld_cnt_nxt    = ld_cnt_r;
    row_valid_nxt = row_valid_r;
    wr_row_nxt    = wr_row_r;
    wr_col_nxt    = wr_col_r;
    wr_val_nxt    = wr_val_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      lcag_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // Fetch the target row for a write, or row 0 for a streaming item.
          ram_rd_en   = 1'b1;
          ram_rd_addr = (in_data.func == lcag_pkg::FUNC_WRITE) ? IDX_W'(in_data.row) : '0;
          wr_row_nxt  = IDX_W'(in_data.row);
          wr_col_nxt  = in_data.col;
          wr_val_nxt  = in_data.cell_value;
          idx_nxt     = '0;
          ld_cnt_nxt  = '0;
          if (in_data.func == lcag_pkg::FUNC_LOAD) begin
            row_valid_nxt = '0;
          end
        end
      end
      lcag_pkg::ST_LOAD: begin
        // One preset row written per cycle.
        ram_wr_en   = 1'b1;
        ram_wr_addr = IDX_W'(ld_cnt_r);
        ram_wr_data = GRID_SIZE'(lcag_pkg::preset_row(pattern_r, ld_cnt_r));
        row_valid_nxt[IDX_W'(ld_cnt_r)] = 1'b1;
        ld_cnt_nxt  = ld_cnt_r + lcag_pkg::LD_CNT_W'(1);
      end
      lcag_pkg::ST_WR_WB: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = wr_row_r;
        ram_wr_data = modified_row;
        row_valid_nxt[wr_row_r] = 1'b1;
      end
      lcag_pkg::ST_ADV_FILL: begin
        // Row 0 enters the window; row 1 is fetched as the first row below.
        prev_nxt    = '0;
        cur_nxt     = rd_row;
        ram_rd_en   = 1'b1;
        ram_rd_addr = IDX_W'(1);
      end
      lcag_pkg::ST_ADV_RUN: begin
        if (step) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = idx_r;
          ram_wr_data = new_row;
          row_valid_nxt[idx_r] = 1'b1;
          out_valid_nxt          = 1'b1;
          out_data_nxt.row_index = lcag_pkg::COORD_W'(idx_r);
          out_data_nxt.row_bits  = lcag_pkg::ROW_BITS_W'(new_row);
          out_data_nxt.last      = (idx_r == LAST_ROW);
          prev_nxt    = cur_r;
          cur_nxt     = below_row;
          if (idx_r < PENULT_ROW) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_r + IDX_W'(2);
          end
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      lcag_pkg::ST_RD_RUN: begin
        if (step) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.row_index = lcag_pkg::COORD_W'(idx_r);
          out_data_nxt.row_bits  = lcag_pkg::ROW_BITS_W'(rd_row);
          out_data_nxt.last      = (idx_r == LAST_ROW);
          if (idx_r != LAST_ROW) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_r + IDX_W'(1);
          end
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // The valid flag of a fetched row is captured alongside the read.
  assign rd_valid_nxt = ram_rd_en ? row_valid_r[ram_rd_addr] : rd_valid_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcag_pkg::ST_IDLE;
      idx_r       <= '0;
      ld_cnt_r    <= '0;
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pattern_r   <= lcag_pkg::PATTERN_GLIDER;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ld_cnt_r    <= ld_cnt_nxt;
      row_valid_r <= row_valid_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        pattern_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    wr_row_r   <= wr_row_nxt;
    wr_col_r   <= wr_col_nxt;
    wr_val_r   <= wr_val_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

>>> test/life_cellular_automaton_grid_unit_tb.sv
// Self-checking testbench for the life cellular automaton grid unit.
// Predicts each emitted row from its grid model or a hand-written grid and compares it as it arrives.
// Depends on lcag_pkg and life_cellular_automaton_grid_unit.
`timescale 1ns / 1ps

module life_cellular_automaton_grid_unit_tb;

  localparam int GRID_N        = 16;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 600;

  // Short local names for the codes used in the stimulus table.
  localparam logic PAT_GLIDER = lcag_pkg::PATTERN_GLIDER;
  localparam logic PAT_TETRIS = lcag_pkg::PATTERN_TETRIS;
  localparam logic [lcag_pkg::FUNC_W-1:0] FN_WRITE = lcag_pkg::FUNC_WRITE;

  typedef logic [GRID_N-1:0][GRID_N-1:0] grid_t;
  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t         kind;
    lcag_pkg::in_item_t item;
    logic               pattern;
    logic               typed;
    grid_t              grid;
  } script_step_t;

  // Grids that can be written down by hand, row 15 leftmost.
  localparam grid_t GRID_EMPTY   = '0;
  localparam grid_t GRID_GLIDER  = {208'd0, 16'h0003, 16'h0006, 16'h0001};
  localparam grid_t GRID_TETRIS  = {160'd0, 16'h0038, 16'h0010, 64'd0};
  localparam grid_t GRID_CORNERS = {16'h8001, 192'd0, 16'h0003, 16'h0006, 16'h8001};

  localparam lcag_pkg::in_item_t OP_LOAD    = {lcag_pkg::FUNC_LOAD, 9'd0};
  localparam lcag_pkg::in_item_t OP_ADVANCE = {lcag_pkg::FUNC_ADVANCE, 9'd0};
  localparam lcag_pkg::in_item_t OP_READ    = {lcag_pkg::FUNC_READ, 9'd0};

  // Directed part: reset contents, both presets, corner cells, still life and oscillator.
  localparam script_step_t DIRECTED_STEPS [0:25] = '{
    '{STEP_ITEM, OP_READ, PAT_GLIDER, 1'b1, GRID_EMPTY},
    '{STEP_CFG, OP_READ, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, OP_LOAD, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, OP_READ, PAT_GLIDER, 1'b1, GRID_GLIDER},
    '{STEP_ITEM, {FN_WRITE, 4'd15, 4'd15, 1'b1}, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, {FN_WRITE, 4'd0, 4'd15, 1'b1}, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, {FN_WRITE, 4'd15, 4'd0, 1'b1}, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, OP_READ, PAT_GLIDER, 1'b1, GRID_CORNERS},
    '{STEP_ITEM, OP_ADVANCE, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, OP_ADVANCE, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, {FN_WRITE, 4'd14, 4'd14, 1'b1}, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, {FN_WRITE, 4'd14, 4'd15, 1'b1}, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, {FN_WRITE, 4'd15, 4'd14, 1'b1}, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, {FN_WRITE, 4'd15, 4'd15, 1'b1}, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, OP_ADVANCE, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, {FN_WRITE, 4'd0, 4'd0, 1'b0}, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, {FN_WRITE, 4'd7, 4'd7, 1'b1}, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, {FN_WRITE, 4'd7, 4'd8, 1'b1}, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, {FN_WRITE, 4'd7, 4'd9, 1'b1}, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, OP_ADVANCE, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, OP_ADVANCE, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_CFG, OP_READ, PAT_TETRIS, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, OP_LOAD, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, OP_READ, PAT_GLIDER, 1'b1, GRID_TETRIS},
    '{STEP_ITEM, OP_ADVANCE, PAT_GLIDER, 1'b0, GRID_EMPTY},
    '{STEP_ITEM, OP_ADVANCE, PAT_GLIDER, 1'b0, GRID_EMPTY}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lcag_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lcag_pkg::out_item_t out_data;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;

  // Model state and the rows still owed by the block.
  grid_t               life_grid = '0;
  logic                preset_sel = PAT_GLIDER;
  lcag_pkg::out_item_t expected_rows [$];
  int                  mismatches = 0;
  int                  rows_checked = 0;
  int                  win_r = 0;
  int                  win_c = 0;

  life_cellular_automaton_grid_unit #(
    .GRID_SIZE(GRID_N)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int live_at(grid_t g, int r, int c);
    if (r < 0 || c < 0 || r >= GRID_N || c >= GRID_N) begin
      return 0;
    end
    return int'(g[r][c]);
  endfunction

  // One generation under birth on three and survival on two or three; the edge is dead.
  function automatic grid_t next_generation(grid_t g);
    grid_t nxt;
    int    n;
    nxt = '0;
    for (int r = 0; r < GRID_N; r++) begin
      for (int c = 0; c < GRID_N; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              n += live_at(g, r + dr, c + dc);
            end
          end
        end
        if (g[r][c]) begin
          nxt[r][c] = (n == 2) || (n == 3);
        end else begin
          nxt[r][c] = (n == 3);
        end
      end
    end
    return nxt;
  endfunction

  task automatic queue_grid(grid_t g);
    lcag_pkg::out_item_t row;
    for (int r = 0; r < GRID_N; r++) begin
      row.row_index = 4'(r);
      row.row_bits  = g[r];
      row.last      = (r == GRID_N - 1);
      expected_rows = {expected_rows, row};
    end
  endtask

  // Applies one accepted item to the model grid and queues the rows it emits.
  task automatic apply_to_grid(lcag_pkg::in_item_t it);
    case (it.func)
      lcag_pkg::FUNC_LOAD: begin
        life_grid = '0;
        if (preset_sel == PAT_TETRIS) begin
          life_grid[4][4] = 1'b1;
          life_grid[5][3] = 1'b1;
          life_grid[5][4] = 1'b1;
          life_grid[5][5] = 1'b1;
        end else begin
          life_grid[0][0] = 1'b1;
          life_grid[1][1] = 1'b1;
          life_grid[1][2] = 1'b1;
          life_grid[2][0] = 1'b1;
          life_grid[2][1] = 1'b1;
        end
      end
      lcag_pkg::FUNC_WRITE: begin
        life_grid[it.row][it.col] = it.cell_value;
      end
      lcag_pkg::FUNC_ADVANCE: begin
        life_grid = next_generation(life_grid);
        queue_grid(life_grid);
      end
      default: begin
        queue_grid(life_grid);
      end
    endcase
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Offers one item from a falling edge and returns at the falling edge after acceptance,
  // leaving valid high so that a following item can go straight on.
  task automatic offer_item(lcag_pkg::in_item_t it, logic typed, grid_t typed_grid);
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (typed) begin
      queue_grid(typed_grid);
    end else begin
      apply_to_grid(it);
    end
    @(negedge clk);
  endtask

  task automatic idle_input(int cycles);
    bit [31:0] junk;
    if (cycles > 0) begin
      junk = $urandom;
      in_valid <= 1'b0;
      in_data  <= junk[$bits(lcag_pkg::in_item_t)-1:0];
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Holds the input off until every owed row has arrived and loads or writes have settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_preset(logic pattern);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pattern;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    preset_sel = pattern;
  endtask

  // Writes mostly land in a small moving window so that live clusters form and evolve.
  function automatic lcag_pkg::in_item_t random_item();
    lcag_pkg::in_item_t it;
    int                 roll;
    roll = $urandom_range(0, 99);
    it.row        = 4'($urandom_range(0, 15));
    it.col        = 4'($urandom_range(0, 15));
    it.cell_value = 1'($urandom_range(0, 1));
    if (roll < 4) begin
      it.func = lcag_pkg::FUNC_LOAD;
      win_r = $urandom_range(0, GRID_N - 5);
      win_c = $urandom_range(0, GRID_N - 5);
    end else if (roll < 58) begin
      it.func = lcag_pkg::FUNC_WRITE;
      if ($urandom_range(0, 3) != 0) begin
        it.row        = 4'(win_r + $urandom_range(0, 4));
        it.col        = 4'(win_c + $urandom_range(0, 4));
        it.cell_value = ($urandom_range(0, 9) < 7);
      end
    end else if (roll < 80) begin
      it.func = lcag_pkg::FUNC_ADVANCE;
      if ($urandom_range(0, 7) == 0) begin
        win_r = $urandom_range(0, GRID_N - 5);
        win_c = $urandom_range(0, GRID_N - 5);
      end
    end else begin
      it.func = lcag_pkg::FUNC_READ;
    end
    return it;
  endfunction

  // One random phase: a preset, a load, then item bursts; gaps mostly up to max_gap.
  task automatic run_random_phase(logic pattern, int n_items, int max_gap, int pause_at);
    int sent;
    int burst;
    program_preset(pattern);
    offer_item(OP_LOAD, 1'b0, GRID_EMPTY);
    sent = 1;
    while (sent < n_items) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && sent < n_items) begin
        offer_item(random_item(), 1'b0, GRID_EMPTY);
        sent++;
        burst--;
        if (sent == pause_at) begin
          wait_idle();
        end
      end
      if (max_gap > 0) begin
        if ($urandom_range(0, 9) == 0) begin
          idle_input($urandom_range(20, 40));
        end else begin
          idle_input($urandom_range(0, max_gap));
        end
      end
    end
  endtask

  // Result checker: every accepted row must match the oldest owed row.
  always @(posedge clk) begin
    lcag_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected row index %0d bits %h last %b",
                                  out_data.row_index, out_data.row_bits, out_data.last));
      end else begin
        want = expected_rows.pop_front();
        if (out_data.row_index !== want.row_index || out_data.row_bits !== want.row_bits ||
            out_data.last !== want.last) begin
          report_mismatch($sformatf(
            "row got idx %0d bits %h last %b, want idx %0d bits %h last %b",
            out_data.row_index, out_data.row_bits, out_data.last,
            want.row_index, want.row_bits, want.last));
        end
      end
      rows_checked++;
    end
  end

  // Output stalls: changing patterns, plus one long hold-off to back the block up.
  initial begin
    int  mode;
    int  span;
    int  stall_tick;
    int  hold_count;
    bit  hold_done;
    stall_tick = 0;
    hold_done  = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(40, 200);
      repeat (span) begin
        @(negedge clk);
        stall_tick++;
        if (!hold_done && rows_checked >= HOLD_AFTER) begin
          hold_done = 1'b1;
          out_ready <= 1'b0;
          hold_count = 0;
          while (hold_count < HOLD_CYCLES) begin
            @(negedge clk);
            hold_count++;
          end
        end else begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (stall_tick % 4 != 3);
            default: out_ready <= ($urandom_range(0, 4) == 0);
          endcase
        end
      end
    end
  end

  // Main sequence: reset, directed steps, random phases, then drain and verdict.
  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (DIRECTED_STEPS[i]) begin
      if (DIRECTED_STEPS[i].kind == STEP_CFG) begin
        program_preset(DIRECTED_STEPS[i].pattern);
      end else begin
        offer_item(DIRECTED_STEPS[i].item, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].grid);
      end
    end
    run_random_phase(PAT_TETRIS, 95, 8, -1);
    run_random_phase(PAT_GLIDER, 95, 0, -1);
    run_random_phase(PAT_TETRIS, 95, 8, 48);
    run_random_phase(PAT_GLIDER, 95, 3, -1);
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
